// File: rtl/gcp_pkg.sv
package gcp_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_BPP_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_RED    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_GREEN  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_BLUE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_ALPHA  = 3'd5;

    localparam logic [1:0] BPP_1 = 2'd0;
    localparam logic [1:0] BPP_2 = 2'd1;
    localparam logic [1:0] BPP_4 = 2'd2;
    localparam logic [1:0] BPP_8 = 2'd3;

    localparam logic [1:0] FMT_RGB565   = 2'd0;
    localparam logic [1:0] FMT_ARGB8565 = 2'd1;
    localparam logic [1:0] FMT_RGBA8888 = 2'd2;

    localparam logic [7:0] ALPHA_LOW  = 8'h40;
    localparam logic [7:0] ALPHA_MID  = 8'hA0;
    localparam logic [7:0] ALPHA_FULL = 8'hFF;

    typedef struct packed {
        logic [1:0] bpp_mode;
        logic [1:0] pixel_format;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [4:0] red5;
        logic [5:0] green6;
        logic [4:0] blue5;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] code;
        logic       last;
    } pix_t;

    // exact x / 255 for any 14-bit x (below 16384)
    function automatic logic [7:0] div255(input logic [13:0] x);
        logic [14:0] t;
        t = {1'b0, x} + 15'(x >> 8) + 15'd1;
        return 8'(t >> 8);
    endfunction

endpackage

// File: rtl/gcp_cfg_regs.sv
module gcp_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [gcp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gcp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output gcp_pkg::cfg_t                      cfg
);

    gcp_pkg::cfg_t cfg_reg;
    gcp_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                gcp_pkg::REG_BPP_MODE: begin
                    cfg_next.bpp_mode = cfg_wdata[1:0];
                end
                gcp_pkg::REG_PIXEL_FORMAT: begin
                    cfg_next.pixel_format = cfg_wdata[1:0];
                end
                gcp_pkg::REG_COLOR_RED: begin
                    cfg_next.red  = cfg_wdata;
                    cfg_next.red5 = 5'(gcp_pkg::div255({6'd0, cfg_wdata} * 14'd31));
                end
                gcp_pkg::REG_COLOR_GREEN: begin
                    cfg_next.green  = cfg_wdata;
                    cfg_next.green6 = 6'(gcp_pkg::div255({6'd0, cfg_wdata} * 14'd63));
                end
                gcp_pkg::REG_COLOR_BLUE: begin
                    cfg_next.blue  = cfg_wdata;
                    cfg_next.blue5 = 5'(gcp_pkg::div255({6'd0, cfg_wdata} * 14'd31));
                end
                gcp_pkg::REG_COLOR_ALPHA: begin
                    cfg_next.alpha = cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{bpp_mode: gcp_pkg::BPP_1, pixel_format: gcp_pkg::FMT_RGB565,
                         red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'hFF,
                         red5: 5'd0, green6: 6'd0, blue5: 5'd0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/gcp_dot_cursor.sv
module gcp_dot_cursor (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [1:0]                       bpp_mode,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gcp_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             advance,
    output gcp_pkg::pix_t                    pix
);

    logic       valid_reg;
    logic [7:0] dots_reg;
    logic [2:0] pos_reg;
    logic [3:0] rem_reg;

    logic [2:0] first;
    logic [3:0] count;
    logic [3:0] per_byte;
    logic [3:0] left;
    logic [3:0] n;
    logic       take;
    logic       accept;
    logic       drain;
    logic [2:0] shift;
    logic [7:0] shifted;
    logic [7:0] mask;

    assign first    = s_tdata[10:8];
    assign count    = s_tdata[14:11];
    assign per_byte = 4'd8 >> bpp_mode;
    assign left     = per_byte - {1'b0, first};
    assign n        = (count < left) ? count : left;
    assign take     = ({1'b0, first} < per_byte) && (n != 4'd0);

    assign drain    = advance && (rem_reg == 4'd1);
    assign s_tready = !valid_reg || drain;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= take;
        end else if (drain) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && take) begin
            dots_reg <= s_tdata[7:0];
            pos_reg  <= first;
            rem_reg  <= n;
        end else if (advance) begin
            pos_reg <= pos_reg + 3'd1;
            rem_reg <= rem_reg - 4'd1;
        end
    end

    assign shift   = pos_reg << bpp_mode;
    assign shifted = dots_reg >> shift;

    always_comb begin
        case (bpp_mode)
            gcp_pkg::BPP_1: mask = 8'h01;
            gcp_pkg::BPP_2: mask = 8'h03;
            gcp_pkg::BPP_4: mask = 8'h0F;
            default:        mask = 8'hFF;
        endcase
    end

    assign pix.valid = valid_reg;
    assign pix.code  = shifted & mask;
    assign pix.last  = (rem_reg == 4'd1);

endmodule

// File: rtl/gcp_pixel_shade.sv
module gcp_pixel_shade (
    input  gcp_pkg::cfg_t   cfg,
    input  logic [7:0]      code,
    output logic [31:0]     pixel_word,
    output logic            write_enable,
    output logic            unsupported
);

    logic [15:0] c565;
    logic [7:0]  blend_alpha;
    logic [4:0]  a5;
    logic [9:0]  prod_r;
    logic [10:0] prod_g;
    logic [9:0]  prod_b;
    logic [15:0] dark565;
    logic        full_code;
    logic [7:0]  alpha;

    assign c565 = {cfg.red5, cfg.green6, cfg.blue5};

    assign unsupported = !(cfg.pixel_format == gcp_pkg::FMT_RGB565 ||
                           cfg.pixel_format == gcp_pkg::FMT_ARGB8565 ||
                           cfg.pixel_format == gcp_pkg::FMT_RGBA8888) ||
                         (cfg.pixel_format == gcp_pkg::FMT_RGB565 &&
                          cfg.bpp_mode == gcp_pkg::BPP_8) ||
                         (cfg.pixel_format == gcp_pkg::FMT_ARGB8565 &&
                          cfg.bpp_mode == gcp_pkg::BPP_1);

    assign write_enable = !unsupported && (code != 8'd0);

    always_comb begin
        if (cfg.bpp_mode == gcp_pkg::BPP_2) begin
            blend_alpha = (code[1:0] == 2'd2) ? gcp_pkg::ALPHA_MID : gcp_pkg::ALPHA_LOW;
            full_code   = (code[1:0] == 2'd3);
        end else begin
            blend_alpha = {code[3:0], code[3:0]};
            full_code   = (cfg.bpp_mode == gcp_pkg::BPP_1) || (code[3:0] == 4'hF);
        end
    end

    // 565 blend over black with alpha rounded to 5 bits
    assign a5      = 5'((9'(blend_alpha) + 9'd4) >> 3);
    assign prod_r  = 10'(cfg.red5 * a5);
    assign prod_g  = 11'(cfg.green6 * a5);
    assign prod_b  = 10'(cfg.blue5 * a5);
    assign dark565 = {prod_r[9:5], prod_g[10:5], prod_b[9:5]};

    always_comb begin
        case (cfg.bpp_mode)
            gcp_pkg::BPP_1: alpha = cfg.alpha;
            gcp_pkg::BPP_2: begin
                if (cfg.pixel_format == gcp_pkg::FMT_ARGB8565) begin
                    case (code[1:0])
                        2'd3:    alpha = gcp_pkg::ALPHA_FULL;
                        2'd2:    alpha = gcp_pkg::ALPHA_MID;
                        default: alpha = gcp_pkg::ALPHA_LOW;
                    endcase
                end else begin
                    alpha = {4{code[1:0]}};
                end
            end
            gcp_pkg::BPP_4: alpha = {code[3:0], code[3:0]};
            default:        alpha = code;
        endcase
    end

    always_comb begin
        pixel_word = 32'd0;
        if (write_enable) begin
            case (cfg.pixel_format)
                gcp_pkg::FMT_RGB565:   pixel_word = {16'd0, full_code ? c565 : dark565};
                gcp_pkg::FMT_ARGB8565: pixel_word = {8'd0, alpha, c565};
                default:               pixel_word = {alpha, cfg.blue, cfg.green, cfg.red};
            endcase
        end
    end

endmodule

// File: rtl/glyph_coverage_to_pixels.sv
// Path: an accepted byte is held in the pixel cursor, and each pixel word is registered at the output.
// Throughput: one pixel word per cycle while m_tready does not stall the output; a byte emits
// 1 to 8 pixels, set by the single pixel cursor; the next byte is taken with its last pixel.
// Bytes that select no pixels are consumed and emit nothing.
// Reset: synchronous active-low aresetn empties both stages and restores register defaults
// (alpha 0xFF, all else 0).
module glyph_coverage_to_pixels (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [gcp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gcp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gcp_pkg::S_TDATA_W-1:0]    s_tdata,  // dot_byte[7:0], first_pixel[10:8],
                                                       // pixel_count[14:11], zero[15]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gcp_pkg::M_TDATA_W-1:0]    m_tdata,  // pixel_word[31:0]
    output logic [gcp_pkg::M_TUSER_W-1:0]    m_tuser,  // write_enable[0], unsupported[1]
    output logic                             m_tlast   // last_pixel
);

    gcp_pkg::cfg_t cfg;
    gcp_pkg::pix_t pix;

    logic        advance;
    logic [31:0] pixel_word;
    logic        write_enable;
    logic        unsupported;

    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic [1:0]  m_user_reg;
    logic        m_last_reg;

    gcp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    gcp_dot_cursor u_cursor (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .bpp_mode (cfg.bpp_mode),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .pix      (pix)
    );

    gcp_pixel_shade u_shade (
        .cfg          (cfg),
        .code         (pix.code),
        .pixel_word   (pixel_word),
        .write_enable (write_enable),
        .unsupported  (unsupported)
    );

    assign advance = pix.valid && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= pixel_word;
            m_user_reg <= {unsupported, write_enable};
            m_last_reg <= pix.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: rtl/gcp_checker.sv
module gcp_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [gcp_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [gcp_pkg::M_TUSER_W-1:0]    m_tuser,
    input logic                             m_tlast
);

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled output word changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && (m_tdata == '0))
        else $error("unsupported word carries a write or a pixel");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0))
        else $error("unwritten pixel has nonzero word");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind glyph_coverage_to_pixels gcp_checker u_gcp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: dv/glyph_pixel_checker.sv
`timescale 1ns / 1ps

module glyph_pixel_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [gcp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gcp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [gcp_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [gcp_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [gcp_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              words_due
);

    localparam logic [63:0] SPREAD_MASK = 64'h7e0f81f;

    typedef struct packed {
        logic [1:0] bpp;
        logic [1:0] fmt;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } text_style_t;

    typedef struct packed {
        logic [31:0] pixel_word;
        logic        write_enable;
        logic        unsupported;
        logic        last_pixel;
    } pixel_t;

    text_style_t style;
    pixel_t      pixel_q[$];

    initial begin
        fail_count = 0;
        words_due  = 0;
    end

    function automatic logic [15:0] pack_565(input text_style_t st);
        int r5;
        int g6;
        int b5;
        r5 = (int'(st.red) * 31) / 255;
        g6 = (int'(st.green) * 63) / 255;
        b5 = (int'(st.blue) * 31) / 255;
        return 16'((r5 << 11) + (g6 << 5) + b5);
    endfunction

    // blend over black with alpha rounded to 5 bits
    function automatic logic [15:0] darken(input logic [15:0] c, input logic [7:0] a);
        logic [63:0] a5;
        logic [63:0] spread;
        logic [63:0] prod;
        a5     = ({56'd0, a} + 64'd4) >> 3;
        spread = ({48'd0, c} | ({48'd0, c} << 16)) & SPREAD_MASK;
        prod   = ((spread * a5) >> 5) & SPREAD_MASK;
        return 16'((prod >> 16) | prod);
    endfunction

    function automatic void expand_byte(input text_style_t st, input logic [7:0] dots,
                                        input logic [2:0] first, input logic [3:0] count);
        int          bits;
        int          per_byte;
        int          n;
        int          shift;
        logic [7:0]  mask;
        logic [7:0]  code;
        logic [7:0]  alpha;
        logic [15:0] c565;
        logic        bad;
        pixel_t      px;
        bits     = 1 << st.bpp;
        per_byte = 8 >> st.bpp;
        mask     = (bits == 8) ? 8'hff : 8'((1 << bits) - 1);
        c565     = pack_565(st);
        if (int'(first) >= per_byte) return;
        n = per_byte - int'(first);
        if (int'(count) < n) n = int'(count);
        bad = (st.fmt > gcp_pkg::FMT_RGBA8888) ||
              (st.fmt == gcp_pkg::FMT_RGB565 && st.bpp == gcp_pkg::BPP_8) ||
              (st.fmt == gcp_pkg::FMT_ARGB8565 && st.bpp == gcp_pkg::BPP_1);
        for (int k = 0; k < n; k++) begin
            shift = ((int'(first) + k) * bits) & 7;
            code  = (dots >> shift) & mask;
            px    = '0;
            alpha = '0;
            if (!bad && code != 8'd0) begin
                px.write_enable = 1'b1;
                if (st.fmt == gcp_pkg::FMT_RGB565) begin
                    case (st.bpp)
                        gcp_pkg::BPP_1: px.pixel_word = {16'd0, c565};
                        gcp_pkg::BPP_2: begin
                            if (code == 8'd3) px.pixel_word = {16'd0, c565};
                            else px.pixel_word = {16'd0, darken(c565,
                                (code == 8'd2) ? gcp_pkg::ALPHA_MID : gcp_pkg::ALPHA_LOW)};
                        end
                        default: begin
                            if (code == 8'd15) px.pixel_word = {16'd0, c565};
                            else px.pixel_word = {16'd0, darken(c565, 8'(17 * code))};
                        end
                    endcase
                end else begin
                    case (st.bpp)
                        gcp_pkg::BPP_1: alpha = st.alpha;
                        gcp_pkg::BPP_2: begin
                            if (st.fmt == gcp_pkg::FMT_ARGB8565)
                                alpha = (code == 8'd3) ? gcp_pkg::ALPHA_FULL :
                                        (code == 8'd2) ? gcp_pkg::ALPHA_MID :
                                        gcp_pkg::ALPHA_LOW;
                            else
                                alpha = 8'(85 * code);
                        end
                        gcp_pkg::BPP_4: alpha = 8'(17 * code);
                        default: alpha = code;
                    endcase
                    if (st.fmt == gcp_pkg::FMT_ARGB8565)
                        px.pixel_word = {8'd0, alpha, c565};
                    else
                        px.pixel_word = {alpha, st.blue, st.green, st.red};
                end
            end
            px.unsupported = bad;
            px.last_pixel  = (k + 1 == n);
            pixel_q.push_back(px);
        end
    endfunction

    always @(posedge aclk) begin
        pixel_t want;
        if (!aresetn) begin
            pixel_q.delete();
            style <= '{bpp: gcp_pkg::BPP_1, fmt: gcp_pkg::FMT_RGB565, red: 8'd0,
                       green: 8'd0, blue: 8'd0, alpha: 8'hff};
        end else begin
            if (m_tvalid && m_tready) begin
                if (pixel_q.size() == 0) begin
                    $error("unexpected pixel word %h", m_tdata);
                    fail_count++;
                end else begin
                    want = pixel_q.pop_front();
                    if (m_tdata !== want.pixel_word) begin
                        $error("pixel_word expected %h actual %h", want.pixel_word, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.write_enable) begin
                        $error("write_enable expected %b actual %b",
                               want.write_enable, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== want.unsupported) begin
                        $error("unsupported expected %b actual %b",
                               want.unsupported, m_tuser[1]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last_pixel) begin
                        $error("last_pixel expected %b actual %b", want.last_pixel, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expand_byte(style, s_tdata[7:0], s_tdata[10:8], s_tdata[14:11]);
            if (cfg_wr_en) begin
                case (cfg_index)
                    gcp_pkg::REG_BPP_MODE:     style.bpp   <= cfg_wdata[1:0];
                    gcp_pkg::REG_PIXEL_FORMAT: style.fmt   <= cfg_wdata[1:0];
                    gcp_pkg::REG_COLOR_RED:    style.red   <= cfg_wdata;
                    gcp_pkg::REG_COLOR_GREEN:  style.green <= cfg_wdata;
                    gcp_pkg::REG_COLOR_BLUE:   style.blue  <= cfg_wdata;
                    gcp_pkg::REG_COLOR_ALPHA:  style.alpha <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        words_due = pixel_q.size();
    end

endmodule

// File: dv/glyph_coverage_to_pixels_test.sv
`timescale 1ns / 1ps

module glyph_coverage_to_pixels_test;

    localparam logic [1:0] FMT_RESERVED = 2'd3;
    localparam int IDLE_PCT    = 38;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;
    localparam int NUM_RANDOM  = 400;
    localparam int LIMIT       = 200000;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [gcp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [gcp_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [gcp_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [gcp_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [gcp_pkg::M_TUSER_W-1:0]   m_tuser;
    logic                            m_tlast;

    int   fail_count;
    int   words_due;
    int   cycle_count = 0;
    bit   src_gaps    = 1'b1;
    bit   sink_steady = 1'b0;
    bit   hold_req    = 1'b0;
    logic [1:0] cur_bpp = gcp_pkg::BPP_1;

    always #4 aclk = ~aclk;

    glyph_coverage_to_pixels dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    glyph_pixel_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .fail_count(fail_count), .words_due(words_due)
    );

    task automatic send_byte(input logic [7:0] dots, input logic [2:0] first,
                             input logic [3:0] count);
        if (src_gaps) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, count, first, dots};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold the input until every word is out and the pipe has emptied
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (words_due == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [gcp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic apply_style(input logic [1:0] bpp, input logic [1:0] fmt,
                               input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic [7:0] a);
        drain();
        write_reg(gcp_pkg::REG_BPP_MODE, {6'h3f, bpp});
        write_reg(gcp_pkg::REG_PIXEL_FORMAT, {6'h2a, fmt});
        write_reg(gcp_pkg::REG_COLOR_RED, r);
        write_reg(gcp_pkg::REG_COLOR_GREEN, g);
        write_reg(gcp_pkg::REG_COLOR_BLUE, b);
        write_reg(gcp_pkg::REG_COLOR_ALPHA, a);
        if ($urandom_range(3) == 0)
            write_reg(gcp_pkg::REG_COLOR_ALPHA + 3'd1 + 3'($urandom_range(1)),
                      8'($urandom()));
        cfg_wr_en <= 1'b0;
        cur_bpp = bpp;
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic send_random();
        int per_byte;
        int first;
        per_byte = 8 >> cur_bpp;
        if ($urandom_range(99) < 80) begin
            first = $urandom_range(per_byte - 1);
            send_byte(8'($urandom()), 3'(first), 4'($urandom_range(per_byte - first, 1)));
        end else begin
            send_byte(8'($urandom()), 3'($urandom_range(7)), 4'($urandom_range(15)));
        end
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                for (int i = 1; i < HOLD_CYCLES; i++) @(posedge aclk);
                hold_req = 1'b0;
            end else if (sink_steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int sent;
        int phase;
        int phase_len;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: 1 bpp RGB565, black
        send_byte(8'hff, 3'd0, 4'd8);
        send_byte(8'h00, 3'd0, 4'd8);

        apply_style(gcp_pkg::BPP_2, gcp_pkg::FMT_RGB565, 8'hff, 8'hff, 8'hff, 8'hff);
        send_byte(8'b1110_0100, 3'd0, 4'd4);
        apply_style(gcp_pkg::BPP_4, gcp_pkg::FMT_RGB565, 8'hff, 8'h00, 8'h80, 8'h00);
        send_byte(8'hf1, 3'd0, 4'd2);
        send_byte(8'h80, 3'd0, 4'd2);
        apply_style(gcp_pkg::BPP_8, gcp_pkg::FMT_RGB565, 8'h55, 8'haa, 8'h33, 8'hff);
        send_byte(8'h55, 3'd0, 4'd1);
        apply_style(gcp_pkg::BPP_1, gcp_pkg::FMT_ARGB8565, 8'hff, 8'hff, 8'hff, 8'hff);
        send_byte(8'ha5, 3'd3, 4'd15);
        apply_style(gcp_pkg::BPP_2, gcp_pkg::FMT_ARGB8565, 8'h12, 8'h34, 8'h56, 8'h78);
        send_byte(8'he4, 3'd0, 4'd4);
        send_byte(8'he4, 3'd4, 4'd4);
        send_byte(8'he4, 3'd1, 4'd0);
        apply_style(gcp_pkg::BPP_8, gcp_pkg::FMT_ARGB8565, 8'h00, 8'h00, 8'h00, 8'h00);
        send_byte(8'h00, 3'd0, 4'd1);
        send_byte(8'hff, 3'd0, 4'd9);
        apply_style(gcp_pkg::BPP_1, gcp_pkg::FMT_RGBA8888, 8'hc3, 8'h3c, 8'h99, 8'h00);
        send_byte(8'h5a, 3'd7, 4'd1);
        send_byte(8'h5a, 3'd2, 4'd8);
        apply_style(gcp_pkg::BPP_2, gcp_pkg::FMT_RGBA8888, 8'hff, 8'h00, 8'hff, 8'h00);
        send_byte(8'h1b, 3'd1, 4'd3);
        apply_style(gcp_pkg::BPP_4, gcp_pkg::FMT_RGBA8888, 8'h01, 8'hfe, 8'h7f, 8'h80);
        send_byte(8'h0f, 3'd1, 4'd1);
        send_byte(8'hf0, 3'd0, 4'd2);
        apply_style(gcp_pkg::BPP_8, gcp_pkg::FMT_RGBA8888, 8'hff, 8'hff, 8'hff, 8'hff);
        send_byte(8'h7f, 3'd0, 4'd1);
        apply_style(gcp_pkg::BPP_1, FMT_RESERVED, 8'hff, 8'hff, 8'hff, 8'hff);
        send_byte(8'hff, 3'd0, 4'd8);
        drain();
        write_reg(gcp_pkg::REG_COLOR_ALPHA + 3'd1, 8'h5a);
        write_reg(gcp_pkg::REG_COLOR_ALPHA + 3'd2, 8'ha5);
        cfg_wr_en <= 1'b0;
        send_byte(8'h81, 3'd0, 4'd8);

        sent  = 0;
        phase = 0;
        while (sent < NUM_RANDOM) begin
            apply_style(2'($urandom_range(3)),
                        ($urandom_range(9) == 0) ? FMT_RESERVED : 2'($urandom_range(2)),
                        pick_level(), pick_level(), pick_level(), pick_level());
            phase_len   = (phase == 2) ? 80 : $urandom_range(50, 15);
            src_gaps    = (phase != 2);
            sink_steady = (phase == 2);
            for (int i = 0; i < phase_len; i++) begin
                if (phase == 1 && i == 4) hold_req = 1'b1;
                if (phase == 3 && i == phase_len / 2) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    wait (words_due == 0);
                    @(posedge aclk);
                end
                send_random();
            end
            sent += phase_len;
            phase++;
        end
        src_gaps    = 1'b1;
        sink_steady = 1'b0;

        drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/gcp_pkg.sv
rtl/gcp_cfg_regs.sv
rtl/gcp_dot_cursor.sv
rtl/gcp_pixel_shade.sv
rtl/glyph_coverage_to_pixels.sv
rtl/gcp_checker.sv
dv/glyph_pixel_checker.sv
dv/glyph_coverage_to_pixels_test.sv
